FILE: rtl/sba_pkg.sv
`timescale 1ns / 1ps
package sba_pkg;

    localparam int STRIDE = 64;
    localparam logic [6:0] LNIL = 7'h7F;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_RESET = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SLOT   = 2'd1,
        ST_INACTIVE  = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    localparam logic CFG_BUFS = 1'b0;
    localparam logic CFG_SIZE = 1'b1;

    typedef struct packed {
        logic [1:0] req_type;
        logic [9:0] buffer_handle;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  granted_handle;
        logic [21:0] buffer_offset;
        logic        grew_slab;
        logic        released_slab;
    } rsp_item_t;

    // controller -> datapath
    typedef struct packed {
        logic start;      // latch request, decide
        logic chain_step; // write one link of a chain
        logic finish;     // commit the result
    } sba_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_chain; // request needs link chaining
        logic chain_done; // all chaining done
    } sba_sts_t;

endpackage

FILE: rtl/sba_ram.sv
`timescale 1ns / 1ps
module sba_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/sba_ctrl.sv
`timescale 1ns / 1ps
module sba_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output sba_pkg::sba_cmd_t cmd,
    input  sba_pkg::sba_sts_t sts
);
    typedef enum logic [2:0] {IDLE, READ, CHAIN, DONE, HOLD} state_t;
    state_t state_reg;
    logic   m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        state_reg <= READ;
                    end
                end
                READ: begin
                    state_reg <= sts.need_chain ? CHAIN : DONE;
                end
                CHAIN: begin
                    if (sts.chain_done) begin
                        state_reg <= DONE;
                    end
                end
                DONE: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= HOLD;
                end
                HOLD: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign s_ready        = (state_reg == IDLE);
    assign m_valid        = m_valid_reg;
    assign cmd.start      = (state_reg == IDLE) && s_valid;
    assign cmd.chain_step = (state_reg == CHAIN);
    assign cmd.finish     = (state_reg == DONE);
endmodule

FILE: rtl/sba_dp.sv
`timescale 1ns / 1ps
module sba_dp #(
    parameter int SLAB_SLOTS        = 16,
    parameter int MAX_BUFS_PER_SLAB = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  sba_pkg::req_item_t req,
    input  sba_pkg::sba_cmd_t  cmd,
    output sba_pkg::sba_sts_t  sts,
    input  logic [6:0]         bufs_cfg,
    input  logic [15:0]        size_cfg,
    output sba_pkg::rsp_item_t rsp
);
    localparam int SW = (SLAB_SLOTS > 1) ? $clog2(SLAB_SLOTS) : 1;
    localparam int LW = SW + 6;
    localparam int NB = (MAX_BUFS_PER_SLAB < 64) ? MAX_BUFS_PER_SLAB : 64;

    // order links carry a null flag in the top bit
    logic [SLAB_SLOTS-1:0] act_reg;
    logic [SW:0]           nxt_reg [SLAB_SLOTS];
    logic [SW:0]           prv_reg [SLAB_SLOTS];
    logic [SW:0]           head_reg, tail_reg;
    logic [6:0]            used_reg [SLAB_SLOTS];
    logic [6:0]            fh_reg   [SLAB_SLOTS];

    sba_pkg::req_item_t    req_reg;
    sba_pkg::rsp_item_t    rsp_reg;
    sba_pkg::rsp_item_t    rsp_next;
    logic [6:0]            n_reg;
    logic                  grow_reg;
    logic                  reset_reg;
    logic [SW-1:0]         tgt_reg;
    logic                  noslot_reg;
    logic [SW:0]           rslot_reg;
    logic [5:0]            ci_reg;
    logic                  fslot_ok_reg;

    logic [6:0] n_c;
    always_comb begin
        n_c = bufs_cfg;
        if (n_c < 7'd1) n_c = 7'd1;
        if (n_c > 7'(NB)) n_c = 7'(NB);
    end

    // lowest free slot
    logic [SW-1:0] free_slot;
    logic          any_free;
    always_comb begin
        free_slot = '0;
        any_free  = 1'b0;
        for (int i = SLAB_SLOTS - 1; i >= 0; i--) begin
            if (!act_reg[i]) begin
                free_slot = SW'(i);
                any_free  = 1'b1;
            end
        end
    end

    // next active slot at or above rslot for reset sweep
    logic [SW-1:0] sweep_slot;
    logic          sweep_any;
    always_comb begin
        sweep_slot = '0;
        sweep_any  = 1'b0;
        for (int i = SLAB_SLOTS - 1; i >= 0; i--) begin
            if (act_reg[i] && (SW+1)'(i) >= rslot_reg) begin
                sweep_slot = SW'(i);
                sweep_any  = 1'b1;
            end
        end
    end

    logic [SW-1:0] hs;
    assign hs = head_reg[SW-1:0];
    logic need_new;
    assign need_new = head_reg[SW] || (used_reg[hs] >= n_c) || (fh_reg[hs] == sba_pkg::LNIL);

    logic alloc_start;
    assign alloc_start = (req.req_type == sba_pkg::REQ_ALLOC);

    logic [9:0] hreq;
    assign hreq = req.buffer_handle;
    logic [SW-1:0] fslot;
    logic          fslot_ok;
    assign fslot_ok = (32'(hreq[9:6]) < SLAB_SLOTS);
    assign fslot    = SW'(hreq[9:6]);

    // link RAM
    logic            we;
    logic [LW-1:0]   waddr, raddr;
    logic [6:0]      wdata, rdata;

    sba_ram #(.WIDTH(7), .DEPTH((1 << SW) * 64)) u_link (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    logic [SW-1:0] ch_slot;
    assign ch_slot = reset_reg ? sweep_slot : tgt_reg;
    logic chain_active;
    assign chain_active = cmd.chain_step && !(reset_reg && !sweep_any);
    logic last_link;
    assign last_link = ({1'b0, ci_reg} + 7'd1 >= n_reg);

    // read address: head of target slab at start
    always_comb begin
        raddr = {tgt_reg, fh_reg[tgt_reg][5:0]};
        if (cmd.start) begin
            raddr = {(need_new ? free_slot : hs), (need_new ? 6'd0 : fh_reg[hs][5:0])};
        end
    end

    logic free_ok;
    assign free_ok = (req_reg.req_type == sba_pkg::REQ_FREE) && act_reg[tgt_reg]
                     && fslot_ok_reg && ({1'b0, req_reg.buffer_handle[5:0]} < n_reg);
    logic alloc_ok;
    assign alloc_ok = (req_reg.req_type == sba_pkg::REQ_ALLOC) && !noslot_reg;

    always_comb begin
        we    = 1'b0;
        waddr = {ch_slot, ci_reg};
        wdata = last_link ? sba_pkg::LNIL : {1'b0, ci_reg + 6'd1};
        if (chain_active) begin
            we = 1'b1;
        end else if (cmd.finish && free_ok) begin
            we    = 1'b1;
            waddr = {tgt_reg, req_reg.buffer_handle[5:0]};
            wdata = fh_reg[tgt_reg];
        end
    end

    assign sts.need_chain = reset_reg || grow_reg;
    assign sts.chain_done = reset_reg ? !sweep_any : last_link;

    // ordering helpers in finish
    logic [SW:0] nx_n [SLAB_SLOTS];
    logic [SW:0] pv_n [SLAB_SLOTS];
    logic [SW:0] hd_n, tl_n;

    logic [SW:0] s_e;
    logic [5:0]  idx;
    logic [6:0]  used_new;
    logic [6:0]  used_old;

    always_comb begin
        for (int i = 0; i < SLAB_SLOTS; i++) begin
            nx_n[i] = nxt_reg[i];
            pv_n[i] = prv_reg[i];
        end
        hd_n = head_reg;
        tl_n = tail_reg;
        s_e  = {1'b0, tgt_reg};
        idx  = fh_reg[tgt_reg][5:0];
        used_old = used_reg[tgt_reg];
        used_new = (used_old < 7'h7F) ? used_old + 7'd1 : used_old;
        if (alloc_ok) begin
            if (grow_reg) begin
                // put at front
                nx_n[tgt_reg] = hd_n;
                pv_n[tgt_reg] = {1'b1, SW'(0)};
                if (!hd_n[SW]) pv_n[hd_n[SW-1:0]] = s_e;
                else tl_n = s_e;
                hd_n = s_e;
            end
            if (used_new >= n_reg && tl_n != s_e) begin
                // unlink then append
                if (!nx_n[tgt_reg][SW]) pv_n[nx_n[tgt_reg][SW-1:0]] = pv_n[tgt_reg];
                if (!pv_n[tgt_reg][SW]) nx_n[pv_n[tgt_reg][SW-1:0]] = nx_n[tgt_reg];
                if (hd_n == s_e) hd_n = nx_n[tgt_reg];
                pv_n[tgt_reg] = tl_n;
                nx_n[tgt_reg] = {1'b1, SW'(0)};
                if (!tl_n[SW]) nx_n[tl_n[SW-1:0]] = s_e;
                else hd_n = s_e;
                tl_n = s_e;
            end
        end else if (free_ok) begin
            if (used_old == 7'd1 || (used_old > 7'd0 && used_old - 7'd1 == n_reg - 7'd1
                                     && hd_n != s_e)) begin
                if (!nx_n[tgt_reg][SW]) pv_n[nx_n[tgt_reg][SW-1:0]] = pv_n[tgt_reg];
                if (!pv_n[tgt_reg][SW]) nx_n[pv_n[tgt_reg][SW-1:0]] = nx_n[tgt_reg];
                if (hd_n == s_e) hd_n = nx_n[tgt_reg];
                if (tl_n == s_e) tl_n = pv_n[tgt_reg];
                nx_n[tgt_reg] = {1'b1, SW'(0)};
                pv_n[tgt_reg] = {1'b1, SW'(0)};
                if (used_old != 7'd1) begin
                    nx_n[tgt_reg] = hd_n;
                    if (!hd_n[SW]) pv_n[hd_n[SW-1:0]] = s_e;
                    else tl_n = s_e;
                    hd_n = s_e;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg  <= '0;
            head_reg <= {1'b1, SW'(0)};
            tail_reg <= {1'b1, SW'(0)};
            for (int i = 0; i < SLAB_SLOTS; i++) begin
                nxt_reg[i]  <= {1'b1, SW'(0)};
                prv_reg[i]  <= {1'b1, SW'(0)};
                used_reg[i] <= '0;
                fh_reg[i]   <= sba_pkg::LNIL;
            end
            reset_reg <= 1'b0;
            grow_reg  <= 1'b0;
        end else if (cmd.start) begin
            req_reg      <= req;
            n_reg        <= n_c;
            ci_reg       <= '0;
            rslot_reg    <= '0;
            fslot_ok_reg <= fslot_ok;
            reset_reg    <= (req.req_type == sba_pkg::REQ_RESET);
            grow_reg     <= alloc_start && need_new && any_free;
            noslot_reg   <= alloc_start && need_new && !any_free;
            tgt_reg      <= alloc_start ? (need_new ? free_slot : hs) : fslot;
            if (alloc_start && need_new && any_free) begin
                // activate the new slab; its links are written in the chain phase
                act_reg[free_slot]  <= 1'b1;
                used_reg[free_slot] <= '0;
                fh_reg[free_slot]   <= '0;
            end
        end else if (chain_active) begin
            if (last_link) begin
                ci_reg <= '0;
                if (reset_reg) begin
                    fh_reg[sweep_slot]   <= '0;
                    used_reg[sweep_slot] <= '0;
                    rslot_reg            <= {1'b0, sweep_slot} + (SW+1)'(1);
                end
            end else begin
                ci_reg <= ci_reg + 6'd1;
            end
        end else if (cmd.finish) begin
            head_reg <= hd_n;
            tail_reg <= tl_n;
            for (int i = 0; i < SLAB_SLOTS; i++) begin
                nxt_reg[i] <= nx_n[i];
                prv_reg[i] <= pv_n[i];
            end
            if (alloc_ok) begin
                fh_reg[tgt_reg]   <= grow_reg ? ((n_reg == 7'd1) ? sba_pkg::LNIL : 7'd1)
                                              : rdata;
                used_reg[tgt_reg] <= used_new;
            end else if (free_ok) begin
                if (used_old == 7'd1) begin
                    act_reg[tgt_reg]  <= 1'b0;
                    fh_reg[tgt_reg]   <= sba_pkg::LNIL;
                    used_reg[tgt_reg] <= '0;
                end else begin
                    fh_reg[tgt_reg] <= {1'b0, req_reg.buffer_handle[5:0]};
                    if (used_old > 7'd0) used_reg[tgt_reg] <= used_old - 7'd1;
                end
            end
        end
    end

    // result
    logic [21:0] off;
    assign off = 22'({16'd0, (grow_reg ? 6'd0 : idx)} * {6'd0, size_cfg});

    always_comb begin
        rsp_next = '0;
        if (req_reg.req_type == sba_pkg::REQ_ALLOC) begin
            if (noslot_reg) begin
                rsp_next.status = sba_pkg::ST_NO_SLOT;
            end else begin
                rsp_next.granted_handle = 10'({tgt_reg, (grow_reg ? 6'd0 : idx)});
                rsp_next.buffer_offset  = off;
                rsp_next.grew_slab      = grow_reg;
            end
        end else if (req_reg.req_type == sba_pkg::REQ_FREE) begin
            if (!fslot_ok_reg || !act_reg[tgt_reg]) begin
                rsp_next.status = sba_pkg::ST_INACTIVE;
            end else if ({1'b0, req_reg.buffer_handle[5:0]} >= n_reg) begin
                rsp_next.status = sba_pkg::ST_BAD_INDEX;
            end else begin
                rsp_next.released_slab = (used_old == 7'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            rsp_reg <= rsp_next;
        end
    end
    assign rsp = rsp_reg;
endmodule

FILE: rtl/slab_buffer_allocator.sv
`timescale 1ns / 1ps
// Slab buffer allocator: one result transfer per request transfer, one request
// in flight at a time. Allocate, free and unknown requests pass through accept,
// link RAM read, commit and result; the result is held while m_ready stays low.
// An allocation that activates a new slot first chains its free list into the
// link RAM, one link per cycle, n links in all, where n is buffers_per_slab
// clamped to 1..64 and to MAX_BUFS_PER_SLAB. A reset request re-chains every
// active slot, n links each, through the same single write port. Configuration
// writes are taken at any time and should be issued only while idle.
module slab_buffer_allocator #(
    parameter int SLAB_SLOTS        = 16,
    parameter int MAX_BUFS_PER_SLAB = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sba_pkg::req_item_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sba_pkg::rsp_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    logic [6:0]  bufs_reg;
    logic [15:0] size_reg;

    // hold configuration; always ready
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bufs_reg <= 7'd64;
            size_reg <= 16'd64;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sba_pkg::CFG_BUFS: bufs_reg <= cfg_data[6:0];
                sba_pkg::CFG_SIZE: size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    sba_pkg::sba_cmd_t cmd;
    sba_pkg::sba_sts_t sts;
    sba_pkg::req_item_t req;

    assign req = s_data;

    sba_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .sts(sts)
    );

    sba_dp #(.SLAB_SLOTS(SLAB_SLOTS), .MAX_BUFS_PER_SLAB(MAX_BUFS_PER_SLAB)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .req(req), .cmd(cmd), .sts(sts),
        .bufs_cfg(bufs_reg), .size_cfg(size_reg), .rsp(m_data)
    );
endmodule

FILE: tb/tb_slab_buffer_allocator.sv
`timescale 1ns / 1ps
// Testbench for slab_buffer_allocator.
// Requests go in on the s_ channel and responses come back on the m_ channel.
// A behavioral copy of the allocator (slab order list, per-slab free lists,
// use counts) runs alongside the block. When a request transfer is accepted,
// this copy computes the response that the block should return, and that
// response is queued. The response monitor compares every m_ transfer, field
// by field, with the oldest queued response. Each directed test covers one
// feature. The random phases then run well-formed alloc/free traffic over a
// range of buffers_per_slab and buffer_size settings, mixed with stray frees,
// reset-all requests and unknown requests.
module tb_slab_buffer_allocator;
    import sba_pkg::*;

    localparam int SLOTS      = 16;
    localparam int ONIL       = -1;
    localparam int CYCLE_CAP  = 3000000;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    req_item_t  s_data;
    logic       m_valid;
    logic       m_ready;
    rsp_item_t  m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [0:0] cfg_index;
    logic [15:0] cfg_data;

    slab_buffer_allocator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Shadow allocator state
    logic [6:0]  bufs_reg;
    logic [15:0] size_reg;
    logic        slab_on [SLOTS];
    int          ord_next [SLOTS];
    int          ord_prev [SLOTS];
    int          ord_head;
    int          ord_tail;
    int          in_use [SLOTS];
    int          free_top [SLOTS];
    int          link_ram [SLOTS*STRIDE];

    rsp_item_t   pending_rsp[$];
    int          live_handles[$];
    int          fail_cnt;
    int          idle_en;
    int          rx_stall;
    longint      cyc;

    function automatic int slab_cap();
        if (bufs_reg == 0) return 1;
        if (bufs_reg > STRIDE) return STRIDE;
        return int'(bufs_reg);
    endfunction

    function automatic void order_unlink(int s);
        int nx;
        int pv;
        nx = ord_next[s];
        pv = ord_prev[s];
        if (nx != ONIL) ord_prev[nx] = pv;
        if (pv != ONIL) ord_next[pv] = nx;
        if (ord_head == s) ord_head = nx;
        if (ord_tail == s) ord_tail = pv;
        ord_next[s] = ONIL;
        ord_prev[s] = ONIL;
    endfunction

    function automatic void order_front(int s);
        if (ord_head == s) return;
        order_unlink(s);
        ord_next[s] = ord_head;
        if (ord_head != ONIL) ord_prev[ord_head] = s;
        else ord_tail = s;
        ord_head = s;
    endfunction

    function automatic void order_back(int s);
        if (ord_tail == s) return;
        order_unlink(s);
        ord_prev[s] = ord_tail;
        if (ord_tail != ONIL) ord_next[ord_tail] = s;
        else ord_head = s;
        ord_tail = s;
    endfunction

    function automatic void rechain(int s, int n);
        for (int i = 0; i < n; i++)
            link_ram[s*STRIDE + i] = (i + 1 < n) ? i + 1 : int'(LNIL);
        free_top[s] = 0;
        in_use[s]   = 0;
    endfunction

    function automatic void shadow_reset();
        bufs_reg = 7'd64;
        size_reg = 16'd64;
        for (int s = 0; s < SLOTS; s++) begin
            slab_on[s]  = 1'b0;
            ord_next[s] = ONIL;
            ord_prev[s] = ONIL;
            in_use[s]   = 0;
            free_top[s] = int'(LNIL);
        end
        ord_head = ONIL;
        ord_tail = ONIL;
        for (int i = 0; i < SLOTS*STRIDE; i++) link_ram[i] = 0;
    endfunction

    // Apply one request to the shadow state and return the response it owes.
    function automatic rsp_item_t allocator_predict(req_item_t rq);
        rsp_item_t r;
        int n;
        int h;
        int s;
        int idx;
        int prior;
        logic need;
        r = '0;
        n = slab_cap();
        case (req_t'(rq.req_type))
            REQ_ALLOC: begin
                h = ord_head;
                need = (h == ONIL) || (in_use[h] >= n) || (free_top[h] == int'(LNIL));
                if (need) begin
                    s = 0;
                    while (s < SLOTS && slab_on[s]) s++;
                    if (s >= SLOTS) begin
                        r.status = ST_NO_SLOT;
                        return r;
                    end
                    slab_on[s]  = 1'b1;
                    ord_next[s] = ONIL;
                    ord_prev[s] = ONIL;
                    rechain(s, n);
                    order_front(s);
                    h = s;
                    r.grew_slab = 1'b1;
                end
                idx = free_top[h] & (STRIDE - 1);
                free_top[h] = link_ram[h*STRIDE + idx];
                if (in_use[h] < 127) in_use[h]++;
                if (in_use[h] >= n) order_back(h);
                r.status         = ST_OK;
                r.granted_handle = 10'(h*STRIDE + idx);
                r.buffer_offset  = 22'(idx * int'(size_reg));
            end
            REQ_FREE: begin
                s   = int'(rq.buffer_handle) / STRIDE;
                idx = int'(rq.buffer_handle) % STRIDE;
                if (s >= SLOTS || !slab_on[s]) begin
                    r.status = ST_INACTIVE;
                end else if (idx >= n) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    prior = in_use[s];
                    link_ram[s*STRIDE + idx] = free_top[s];
                    free_top[s] = idx;
                    if (prior > 0) in_use[s] = prior - 1;
                    if (prior == 1) begin
                        order_unlink(s);
                        slab_on[s]  = 1'b0;
                        free_top[s] = int'(LNIL);
                        in_use[s]   = 0;
                        r.released_slab = 1'b1;
                    end else if (prior > 0 && in_use[s] == n - 1) begin
                        order_front(s);
                    end
                end
            end
            REQ_RESET: begin
                for (int k = 0; k < SLOTS; k++)
                    if (slab_on[k]) rechain(k, n);
            end
            default: ;
        endcase
        return r;
    endfunction

    // Cycle counter and watchdog
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_CAP) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Response checker: compare each transfer against the oldest expectation.
    always @(posedge aclk) begin
        rsp_item_t want;
        if (aresetn && m_valid && m_ready) begin
            rx_stall = idle_en ? $urandom_range(0, 10) : 0;
            if (pending_rsp.size() == 0) begin
                $error("unexpected response %h", m_data);
                fail_cnt++;
            end else begin
                want = pending_rsp.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    fail_cnt++;
                end
                if (m_data.granted_handle !== want.granted_handle) begin
                    $error("granted_handle: expected %0d, got %0d",
                           want.granted_handle, m_data.granted_handle);
                    fail_cnt++;
                end
                if (m_data.buffer_offset !== want.buffer_offset) begin
                    $error("buffer_offset: expected %0d, got %0d",
                           want.buffer_offset, m_data.buffer_offset);
                    fail_cnt++;
                end
                if (m_data.grew_slab !== want.grew_slab) begin
                    $error("grew_slab: expected %0b, got %0b", want.grew_slab, m_data.grew_slab);
                    fail_cnt++;
                end
                if (m_data.released_slab !== want.released_slab) begin
                    $error("released_slab: expected %0b, got %0b",
                           want.released_slab, m_data.released_slab);
                    fail_cnt++;
                end
            end
        end
    end

    // Receiver back-pressure: hold m_ready low for the drawn stall, then raise it.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            m_ready <= 1'b0;
            rx_stall--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Send one request; must be called at a falling edge, returns at one.
    task automatic send_req(input req_t kind, input logic [9:0] handle,
                            output rsp_item_t owed);
        int gap;
        req_item_t rq;
        gap = idle_en ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        rq.req_type      = kind;
        rq.buffer_handle = handle;
        s_data  <= rq;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        owed = allocator_predict(rq);
        pending_rsp.push_back(owed);
        @(negedge aclk);
    endtask

    // Drain all outstanding responses, let the block settle, then write a register.
    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        s_valid <= 1'b0;
        wait (pending_rsp.size() == 0);
        repeat (40) @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_BUFS) bufs_reg = val[6:0];
        else size_reg = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic do_alloc();
        rsp_item_t r;
        send_req(REQ_ALLOC, 10'd0, r);
        if (r.status == ST_OK) live_handles.push_back(int'(r.granted_handle));
    endtask

    task automatic do_free_live();
        rsp_item_t r;
        int k;
        int h;
        k = $urandom_range(0, live_handles.size() - 1);
        h = live_handles[k];
        live_handles.delete(k);
        send_req(REQ_FREE, 10'(h), r);
    endtask

    task automatic do_reset_all();
        rsp_item_t r;
        send_req(REQ_RESET, 10'($urandom), r);
        live_handles.delete();
    endtask

    // Allocate then free back: growth, offsets, release, free of inactive slab.
    task automatic test_alloc_free();
        rsp_item_t r;
        write_reg(CFG_SIZE, 16'd65535);
        repeat (3) do_alloc();
        while (live_handles.size() > 0) do_free_live();
        send_req(REQ_FREE, 10'd1023, r);
        send_req(REQ_FREE, 10'd0, r);
    endtask

    // Index past buffers_per_slab, and a full slab that frees back to the front.
    task automatic test_bad_index_and_front();
        rsp_item_t r;
        write_reg(CFG_BUFS, 16'd2);
        write_reg(CFG_SIZE, 16'd8);
        repeat (3) do_alloc();
        send_req(REQ_FREE, 10'd63, r);
        send_req(REQ_FREE, 10'd2, r);
        send_req(REQ_FREE, 10'd0, r);
        do_alloc();
        do_reset_all();
    endtask

    // Exhaust the pool with one buffer per slab, then reset and free after reset.
    task automatic test_pool_exhaust();
        rsp_item_t r;
        write_reg(CFG_BUFS, 16'd0);
        repeat (18) do_alloc();
        send_req(REQ_RESET, 10'd0, r);
        send_req(REQ_FREE, 10'd64, r);
        send_req(REQ_ALLOC, 10'd0, r);
        send_req(REQ_NONE, 10'd1023, r);
        send_req(REQ_NONE, 10'd0, r);
        live_handles.delete();
    endtask

    // Mostly valid alloc/free traffic, with noise, resets and unknown requests.
    task automatic test_random(input int count, input logic [6:0] bufs,
                               input logic [15:0] bsize, input int lean_alloc);
        rsp_item_t r;
        int pick;
        write_reg(CFG_BUFS, 16'(bufs));
        write_reg(CFG_SIZE, bsize);
        idle_en = 1;
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 50) idle_en = 0;
            if (i % 100 == 75) idle_en = 1;
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                do_reset_all();
            end else if (pick < 4) begin
                send_req(REQ_NONE, 10'($urandom), r);
            end else if (pick < 12) begin
                send_req(REQ_FREE, 10'($urandom), r);
            end else if (live_handles.size() == 0 || pick < 12 + lean_alloc) begin
                do_alloc();
            end else begin
                do_free_live();
            end
        end
        idle_en = 1;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        m_ready   = 1'b0;
        fail_cnt  = 0;
        idle_en   = 1;
        rx_stall  = 0;
        cyc       = 0;
        shadow_reset();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_alloc_free();
        test_bad_index_and_front();
        test_pool_exhaust();
        test_random(280, 7'd64, 16'd65535, 50);
        test_random(280, 7'd1, 16'd8, 50);
        test_random(280, 7'd127, 16'($urandom_range(8, 65535)), 40);
        test_random(280, 7'd4, 16'($urandom_range(8, 65535)), 55);
        test_random(280, 7'($urandom_range(1, 64)), 16'd43690, 50);
        test_random(280, 7'd3, 16'd21845, 60);

        s_valid <= 1'b0;
        wait (pending_rsp.size() == 0);
        repeat (100) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
